### rtl/scl_pkg.sv
// Shared constants, types and helper functions of the source line classifier.
`timescale 1ns / 1ps

package scl_pkg;

   localparam int MARKER_BYTES    = 8;   // compare window, 1..8
   localparam int COUNT_WIDTH     = 32;  // counter width, 16..32
   localparam int OUT_WIDTH       = 32;
   localparam int CODE_WIDTH      = OUT_WIDTH + 1;
   localparam int MARKER_WIDTH    = 64;
   localparam int LEN_WIDTH       = 4;
   localparam int BYTE_SEL_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_WIDTH  = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [7:0] NL_BYTE = 8'h0A;
   localparam logic [7:0] SP_BYTE = 8'h20;
   localparam logic [7:0] HT_BYTE = 8'h09;
   localparam logic [7:0] CR_BYTE = 8'h0D;
   localparam logic [7:0] VT_BYTE = 8'h0B;
   localparam logic [7:0] FF_BYTE = 8'h0C;

   // Register indexes of the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_MARKER      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_MARKER_LEN  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPEN_MARKER      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPEN_MARKER_LEN  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOSE_MARKER     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOSE_MARKER_LEN = 3'd5;

   // Line phase codes
   localparam logic [1:0] PHASE_SKIP = 2'd0;
   localparam logic [1:0] PHASE_CMP  = 2'd1;
   localparam logic [1:0] PHASE_PAST = 2'd2;

   typedef struct packed {
      logic [MARKER_WIDTH-1:0] line_marker;
      logic [LEN_WIDTH-1:0]    line_len;
      logic [MARKER_WIDTH-1:0] open_marker;
      logic [LEN_WIDTH-1:0]    open_len;
      logic [MARKER_WIDTH-1:0] close_marker;
      logic [LEN_WIDTH-1:0]    close_len;
   } cfg_type;

   // One line-level update for the counters
   typedef struct packed {
      logic       line_inc;
      logic       blank_inc;
      logic [1:0] comment_inc;
      logic       emit;
   } line_ev_type;

   function automatic logic [LEN_WIDTH-1:0] eff_len(input logic [LEN_WIDTH-1:0] len);
      logic [LEN_WIDTH-1:0] lim;
      lim = LEN_WIDTH'(MARKER_BYTES);
      return (len > lim) ? lim : len;
   endfunction

   function automatic logic [7:0] marker_byte(input logic [MARKER_WIDTH-1:0] m,
                                              input logic [BYTE_SEL_WIDTH-1:0] k);
      return m[8*k +: 8];
   endfunction

endpackage

### rtl/source_line_classifier_top.sv
// Top level of the source line classifier: csr registers, front end, event queue, back end.
`timescale 1ns / 1ps

// Source line classifier. Feed a file one byte per transaction on the req_ channel
// (req_byte_present marks a real byte, req_file_end closes the file); one result with
// total, comment, blank and code line counts comes out on the rsp_ channel per file end,
// after which the counters start over. A byte is taken every cycle while req_ready is high:
// the front end classifies it in the cycle it is accepted, and any line or file event it
// produces goes into a four-entry queue that the counter back end drains at one event per
// cycle, holding a file end while a result is unread. req_ready drops only when that queue
// is full, which happens only while a finished result sits unread on rsp_ and further events
// back up behind it. A file end passes the queue and rsp_valid registers. Counters saturate
// at all ones. The user must write marker registers on the csr_ port (always ready) only
// while no file is in progress (not enforced); indexes past the last register are ignored.

module source_line_classifier_top (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [7:0]                                 req_text_byte,
   input  logic                                       req_byte_present,
   input  logic                                       req_file_end,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [scl_pkg::OUT_WIDTH-1:0]              rsp_line_count,
   output logic [scl_pkg::OUT_WIDTH-1:0]              rsp_comment_lines,
   output logic [scl_pkg::OUT_WIDTH-1:0]              rsp_blank_count,
   output logic signed [scl_pkg::CODE_WIDTH-1:0]      rsp_code_count,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [scl_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [scl_pkg::CSR_DATA_WIDTH-1:0]         csr_data
);

   scl_pkg::cfg_type     cfg_ff, cfg_in;
   scl_pkg::line_ev_type front_ev, head_ev;
   logic                 front_ev_valid, req_accept;
   logic                 fifo_full, fifo_not_empty, fifo_pop;

   // csr writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            scl_pkg::CSR_LINE_MARKER:      cfg_in.line_marker  = csr_data;
            scl_pkg::CSR_LINE_MARKER_LEN:  cfg_in.line_len     = csr_data[scl_pkg::LEN_WIDTH-1:0];
            scl_pkg::CSR_OPEN_MARKER:      cfg_in.open_marker  = csr_data;
            scl_pkg::CSR_OPEN_MARKER_LEN:  cfg_in.open_len     = csr_data[scl_pkg::LEN_WIDTH-1:0];
            scl_pkg::CSR_CLOSE_MARKER:     cfg_in.close_marker = csr_data;
            scl_pkg::CSR_CLOSE_MARKER_LEN: cfg_in.close_len    = csr_data[scl_pkg::LEN_WIDTH-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A transaction is refused only while the event queue is full
   assign req_ready  = !fifo_full;
   assign req_accept = req_valid && req_ready;

   scl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .accept       (req_accept),
      .text_byte    (req_text_byte),
      .byte_present (req_byte_present),
      .file_end     (req_file_end),
      .ev_valid     (front_ev_valid),
      .ev           (front_ev)
   );

   scl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && front_ev_valid),
      .push_data (front_ev),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .not_empty (fifo_not_empty),
      .head      (head_ev)
   );

   scl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .ev_avail          (fifo_not_empty),
      .ev                (head_ev),
      .ev_pop            (fifo_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_count    (rsp_line_count),
      .rsp_comment_lines (rsp_comment_lines),
      .rsp_blank_count   (rsp_blank_count),
      .rsp_code_count    (rsp_code_count)
   );

endmodule

### rtl/scl_front.sv
// Front end: per-byte marker matching and line classification into counter events.
`timescale 1ns / 1ps

module scl_front (
   input  logic                 clock,
   input  logic                 reset,
   input  scl_pkg::cfg_type     cfg,
   input  logic                 accept,
   input  logic [7:0]           text_byte,
   input  logic                 byte_present,
   input  logic                 file_end,
   output logic                 ev_valid,
   output scl_pkg::line_ev_type ev
);

   logic [1:0]                    phase_ff, phase_in;
   logic [scl_pkg::LEN_WIDTH-1:0] off_ff, off_in;
   logic [2:0]                    alive_ff, alive_in;
   logic                          lopen_ff, lopen_in;
   logic                          inblk_ff, inblk_in;

   logic [1:0]                    a_phase;
   logic [scl_pkg::LEN_WIDTH-1:0] a_off;
   logic [2:0]                    a_alive;
   logic                          a_lopen;
   logic [scl_pkg::LEN_WIDTH-1:0] eff_l, eff_o, eff_c;
   logic                          is_space, is_nl;
   logic                          do_compare, byte_finish, byte_blank, do_finish;
   logic                          line_hit, inblk_n;
   logic [1:0]                    cinc;

   always_comb begin
      eff_l = scl_pkg::eff_len(cfg.line_len);
      eff_o = scl_pkg::eff_len(cfg.open_len);
      eff_c = scl_pkg::eff_len(cfg.close_len);
      is_nl = (text_byte == scl_pkg::NL_BYTE);
      is_space = (text_byte == scl_pkg::SP_BYTE) || (text_byte == scl_pkg::HT_BYTE) ||
                 (text_byte == scl_pkg::CR_BYTE) || (text_byte == scl_pkg::VT_BYTE) ||
                 (text_byte == scl_pkg::FF_BYTE);

      a_phase     = phase_ff;
      a_off       = off_ff;
      a_alive     = alive_ff;
      a_lopen     = lopen_ff;
      do_compare  = 1'b0;
      byte_finish = 1'b0;
      byte_blank  = 1'b0;

      if (byte_present) begin
         a_lopen = 1'b1;
         if (phase_ff == scl_pkg::PHASE_SKIP) begin
            if (!is_space) begin
               if (is_nl && !inblk_ff) begin
                  byte_blank = 1'b1;
               end else begin
                  do_compare  = 1'b1;
                  byte_finish = is_nl;
               end
            end
         end else begin
            do_compare  = (phase_ff == scl_pkg::PHASE_CMP);
            byte_finish = is_nl;
         end
      end

      if (do_compare) begin
         if (off_ff < eff_l &&
             text_byte != scl_pkg::marker_byte(cfg.line_marker,
                                               off_ff[scl_pkg::BYTE_SEL_WIDTH-1:0])) begin
            a_alive[0] = 1'b0;
         end
         if (off_ff < eff_o &&
             text_byte != scl_pkg::marker_byte(cfg.open_marker,
                                               off_ff[scl_pkg::BYTE_SEL_WIDTH-1:0])) begin
            a_alive[1] = 1'b0;
         end
         if (off_ff < eff_c &&
             text_byte != scl_pkg::marker_byte(cfg.close_marker,
                                               off_ff[scl_pkg::BYTE_SEL_WIDTH-1:0])) begin
            a_alive[2] = 1'b0;
         end
         a_off   = off_ff + scl_pkg::LEN_WIDTH'(1);
         a_phase = (a_off >= scl_pkg::LEN_WIDTH'(scl_pkg::MARKER_BYTES)) ?
                   scl_pkg::PHASE_PAST : scl_pkg::PHASE_CMP;
      end

      // a newline or a file end closes at most one line per transaction
      do_finish = byte_finish || (file_end && a_lopen && !byte_blank);

      line_hit = (eff_l != '0) && a_alive[0] && (a_off >= eff_l);
      inblk_n  = inblk_ff;
      cinc     = 2'd0;
      if (do_finish) begin
         if (line_hit) begin
            cinc = cinc + 2'd1;
         end
         if (eff_o != '0) begin
            if (!inblk_ff) begin
               if (a_alive[1] && a_off >= eff_o) begin
                  inblk_n = 1'b1;
               end
            end else if (a_alive[2] && a_off >= eff_c) begin
               cinc    = cinc + 2'd1;
               inblk_n = 1'b0;
            end
         end
         if (inblk_n) begin
            cinc = cinc + 2'd1;
         end
      end

      phase_in = phase_ff;
      off_in   = off_ff;
      alive_in = alive_ff;
      lopen_in = lopen_ff;
      inblk_in = inblk_ff;
      if (accept) begin
         if (file_end) begin
            phase_in = scl_pkg::PHASE_SKIP;
            off_in   = '0;
            alive_in = 3'b111;
            lopen_in = 1'b0;
            inblk_in = 1'b0;
         end else if (do_finish || byte_blank) begin
            phase_in = scl_pkg::PHASE_SKIP;
            off_in   = '0;
            alive_in = 3'b111;
            lopen_in = 1'b0;
            inblk_in = inblk_n;
         end else begin
            phase_in = a_phase;
            off_in   = a_off;
            alive_in = a_alive;
            lopen_in = a_lopen;
         end
      end

      ev.line_inc    = do_finish || byte_blank;
      ev.blank_inc   = byte_blank;
      ev.comment_inc = cinc;
      ev.emit        = file_end;
      ev_valid       = do_finish || byte_blank || file_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= scl_pkg::PHASE_SKIP;
         off_ff   <= '0;
         alive_ff <= 3'b111;
         lopen_ff <= 1'b0;
         inblk_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         off_ff   <= off_in;
         alive_ff <= alive_in;
         lopen_ff <= lopen_in;
         inblk_ff <= inblk_in;
      end
   end

endmodule

### rtl/scl_fifo.sv
// Small event queue between the classifier front end and the counter back end.
`timescale 1ns / 1ps

module scl_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  scl_pkg::line_ev_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output scl_pkg::line_ev_type head
);

   scl_pkg::line_ev_type                mem_ff [scl_pkg::FIFO_DEPTH];
   logic [scl_pkg::FIFO_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [scl_pkg::FIFO_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [scl_pkg::FIFO_PTR_WIDTH:0]    count_ff, count_in;
   logic                                do_push, do_pop;

   assign full      = (count_ff == (scl_pkg::FIFO_PTR_WIDTH+1)'(scl_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + scl_pkg::FIFO_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + scl_pkg::FIFO_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (scl_pkg::FIFO_PTR_WIDTH+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (scl_pkg::FIFO_PTR_WIDTH+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/scl_back.sv
// Back end: saturating line counters and the registered totals result.
`timescale 1ns / 1ps

module scl_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               ev_avail,
   input  scl_pkg::line_ev_type               ev,
   output logic                               ev_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [scl_pkg::OUT_WIDTH-1:0]      rsp_line_count,
   output logic [scl_pkg::OUT_WIDTH-1:0]      rsp_comment_lines,
   output logic [scl_pkg::OUT_WIDTH-1:0]      rsp_blank_count,
   output logic signed [scl_pkg::CODE_WIDTH-1:0] rsp_code_count
);

   localparam int CW = scl_pkg::COUNT_WIDTH;

   logic [CW-1:0]   total_ff, total_in, comment_ff, comment_in, blank_ff, blank_in;
   logic [CW-1:0]   total_n, comment_n, blank_n;
   logic [CW+1:0]   comment_sum;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [scl_pkg::OUT_WIDTH-1:0] out_total_ff, out_comment_ff, out_blank_ff;
   logic            out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ev_pop   = ev_avail && (!ev.emit || out_free);

   always_comb begin
      total_n = total_ff;
      if (ev.line_inc && total_ff != scl_pkg::COUNT_MAX) begin
         total_n = total_ff + CW'(1);
      end
      blank_n = blank_ff;
      if (ev.blank_inc && blank_ff != scl_pkg::COUNT_MAX) begin
         blank_n = blank_ff + CW'(1);
      end
      comment_sum = {2'b00, comment_ff} + (CW+2)'(ev.comment_inc);
      comment_n   = (comment_sum > {2'b00, scl_pkg::COUNT_MAX}) ?
                    scl_pkg::COUNT_MAX : comment_sum[CW-1:0];

      total_in     = total_ff;
      comment_in   = comment_ff;
      blank_in     = blank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ev_pop) begin
         if (ev.emit) begin
            total_in     = '0;
            comment_in   = '0;
            blank_in     = '0;
            rsp_valid_in = 1'b1;
         end else begin
            total_in   = total_n;
            comment_in = comment_n;
            blank_in   = blank_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         comment_ff   <= '0;
         blank_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         comment_ff   <= comment_in;
         blank_ff     <= blank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop && ev.emit) begin
         out_total_ff   <= scl_pkg::OUT_WIDTH'(total_n);
         out_comment_ff <= scl_pkg::OUT_WIDTH'(comment_n);
         out_blank_ff   <= scl_pkg::OUT_WIDTH'(blank_n);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_count    = out_total_ff;
   assign rsp_comment_lines = out_comment_ff;
   assign rsp_blank_count   = out_blank_ff;
   assign rsp_code_count    = signed'({1'b0, out_total_ff} - {1'b0, out_comment_ff}
                                      - {1'b0, out_blank_ff});

endmodule

### tb/tb.sv
// Self-checking testbench for source_line_classifier_top: directed table, then random files.
`timescale 1ns / 1ps

module tb;

   import scl_pkg::*;

   // Run length and pacing
   localparam int ITEM_GOAL      = 1550;  // byte/end transactions to send
   localparam int CALM_AFTER     = 1400;  // no idling on either side past this point
   localparam int DRAIN_CYCLES   = 12;    // margin for the result path plus the 4-deep event queue
   localparam int WATCHDOG_LIMIT = 500;   // cycles with no handshake on any channel
   localparam int REPORT_LIMIT   = 20;

   // Indexes past the last register; the block must ignore writes to them
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 3'd7;

   // Bytes markers are built from: / * # - ! ; < >
   localparam logic [63:0] MARK_SET = 64'h3E3C3B212D232A2F;

   typedef struct packed {
      logic [OUT_WIDTH-1:0]         total;
      logic [OUT_WIDTH-1:0]         comment;
      logic [OUT_WIDTH-1:0]         blank;
      logic signed [CODE_WIDTH-1:0] code;
   } counts_t;

   // One row of the directed table. retune: drain and load C-style markers first.
   // typed: the expected totals are written in the row instead of predicted.
   typedef struct packed {
      logic [7:0] text;
      logic       present;
      logic       fin;
      logic       retune;
      logic       typed;
      counts_t    want;
   } dir_row_t;

   // ---------------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ---------------------------------------------------------------------------------
   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_text_byte    = 8'h00;
   logic                         req_byte_present = 1'b0;
   logic                         req_file_end     = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready        = 1'b0;
   logic [OUT_WIDTH-1:0]         rsp_line_count;
   logic [OUT_WIDTH-1:0]         rsp_comment_lines;
   logic [OUT_WIDTH-1:0]         rsp_blank_count;
   logic signed [CODE_WIDTH-1:0] rsp_code_count;
   logic                         csr_valid        = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_data         = '0;

   source_line_classifier_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_byte_present (req_byte_present),
      .req_file_end     (req_file_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_count   (rsp_line_count),
      .rsp_comment_lines(rsp_comment_lines),
      .rsp_blank_count  (rsp_blank_count),
      .rsp_code_count   (rsp_code_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Line classifier predictor: its own copy of the registers and line state
   // ---------------------------------------------------------------------------------
   cfg_type              cfg_m = '0;
   logic                 in_block;
   logic [1:0]           line_step;       // PHASE_SKIP / PHASE_CMP / PHASE_PAST
   logic [LEN_WIDTH-1:0] cmp_pos;         // bytes compared so far in this line
   logic [2:0]           live_mask;       // bit 0 line, bit 1 open, bit 2 close
   logic                 line_has_bytes;
   logic [COUNT_WIDTH-1:0] n_total, n_comment, n_blank;

   counts_t   exp_counts_q [$];   // totals still owed by the block, oldest first
   dir_row_t  dir_rows [$];
   logic [7:0] file_bytes [$];    // bytes of the file being sent

   int  mismatches   = 0;
   int  items_sent   = 0;
   int  bytes_sent   = 0;
   int  files_seen   = 0;
   int  setups       = 0;
   int  idle_cycles  = 0;
   int  rsp_run      = 0;
   bit  quiet_tail   = 1'b0;
   counts_t head;

   function automatic logic [LEN_WIDTH-1:0] win_len(input logic [LEN_WIDTH-1:0] len);
      return (len > LEN_WIDTH'(MARKER_BYTES)) ? LEN_WIDTH'(MARKER_BYTES) : len;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
   endfunction

   function automatic bit lead_space(input logic [7:0] b);
      return b == SP_BYTE || b == HT_BYTE || b == CR_BYTE || b == VT_BYTE || b == FF_BYTE;
   endfunction

   function automatic bit hit(input logic [1:0] which, input logic [LEN_WIDTH-1:0] len);
      return live_mask[which] && (cmp_pos >= win_len(len));
   endfunction

   function automatic void restart_line();
      line_step      = PHASE_SKIP;
      cmp_pos        = '0;
      live_mask      = 3'b111;
      line_has_bytes = 1'b0;
   endfunction

   function automatic void wipe_counts();
      in_block  = 1'b0;
      n_total   = '0;
      n_comment = '0;
      n_blank   = '0;
      restart_line();
   endfunction

   // Compare one byte of the window against all three markers
   function automatic void match_step(input logic [7:0] b);
      logic [2:0] k;
      if (cmp_pos >= LEN_WIDTH'(MARKER_BYTES)) begin
         line_step = PHASE_PAST;
         return;
      end
      k = cmp_pos[2:0];
      if (cmp_pos < win_len(cfg_m.line_len) && b != cfg_m.line_marker[8*k +: 8])
         live_mask[0] = 1'b0;
      if (cmp_pos < win_len(cfg_m.open_len) && b != cfg_m.open_marker[8*k +: 8])
         live_mask[1] = 1'b0;
      if (cmp_pos < win_len(cfg_m.close_len) && b != cfg_m.close_marker[8*k +: 8])
         live_mask[2] = 1'b0;
      cmp_pos   = cmp_pos + LEN_WIDTH'(1);
      line_step = (cmp_pos >= LEN_WIDTH'(MARKER_BYTES)) ? PHASE_PAST : PHASE_CMP;
   endfunction

   // End-of-line rules; a line may add two comments
   function automatic void close_line();
      n_total = sat_inc(n_total);
      if (win_len(cfg_m.line_len) != '0 && hit(2'd0, cfg_m.line_len))
         n_comment = sat_inc(n_comment);
      if (win_len(cfg_m.open_len) != '0) begin
         if (!in_block) begin
            if (hit(2'd1, cfg_m.open_len))
               in_block = 1'b1;
         end else if (hit(2'd2, cfg_m.close_len)) begin
            n_comment = sat_inc(n_comment);
            in_block  = 1'b0;
         end
      end
      if (in_block)
         n_comment = sat_inc(n_comment);
      restart_line();
   endfunction

   // Advance the predictor by one accepted transaction; returns 1 when totals come out
   function automatic bit predict_item(input logic [7:0] b, input logic pres,
                                       input logic fin, output counts_t res);
      res = '0;
      if (pres) begin
         line_has_bytes = 1'b1;
         if (line_step == PHASE_SKIP) begin
            if (!lead_space(b)) begin
               if (b == NL_BYTE && !in_block) begin
                  n_total = sat_inc(n_total);
                  n_blank = sat_inc(n_blank);
                  restart_line();
               end else begin
                  match_step(b);
                  if (b == NL_BYTE)
                     close_line();
               end
            end
         end else begin
            if (line_step == PHASE_CMP)
               match_step(b);
            if (b == NL_BYTE)
               close_line();
         end
      end
      if (!fin)
         return 1'b0;
      if (line_has_bytes)
         close_line();
      res.total   = n_total;
      res.comment = n_comment;
      res.blank   = n_blank;
      res.code    = {1'b0, n_total} - {1'b0, n_comment} - {1'b0, n_blank};
      wipe_counts();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Result channel: compare each accepted transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         files_seen++;
         if (exp_counts_q.size() == 0) begin
            note_mismatch($sformatf("result with nothing expected, total %0d",
                                    rsp_line_count));
         end else begin
            head = exp_counts_q.pop_front();
            if (rsp_line_count !== head.total)
               note_mismatch($sformatf("file %0d line count %0d, want %0d",
                                       files_seen, rsp_line_count, head.total));
            if (rsp_comment_lines !== head.comment)
               note_mismatch($sformatf("file %0d comment_lines %0d, want %0d",
                                       files_seen, rsp_comment_lines, head.comment));
            if (rsp_blank_count !== head.blank)
               note_mismatch($sformatf("file %0d blank count %0d, want %0d",
                                       files_seen, rsp_blank_count, head.blank));
            if (rsp_code_count !== head.code)
               note_mismatch($sformatf("file %0d code count %h, want %h",
                                       files_seen, rsp_code_count, head.code));
         end
      end
   end

   // Result-side back-pressure: random stall bursts between ready runs, some of the
   // ready runs long; always ready in the closing stretch.
   always @(negedge clock) begin
      if (quiet_tail) begin
         rsp_ready <= 1'b1;
      end else if (rsp_run > 0) begin
         rsp_run--;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         rsp_run = $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
         rsp_run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 7);
      end
   end

   // Watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, exp_counts_q.size());
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   // One request transaction. Valid rises at a falling edge and holds until accepted;
   // an idle gap may follow.
   task automatic send_item(input logic [7:0] b, input logic pres, input logic fin,
                            input logic typed, input counts_t want);
      counts_t got;
      bit      fires;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_text_byte    <= b;
      req_byte_present <= pres;
      req_file_end     <= fin;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      fires = predict_item(b, pres, fin, got);
      if (fires)
         exp_counts_q.push_back(typed ? want : got);
      if (pres || fin)
         items_sent++;
      if (pres)
         bytes_sent++;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 7))
            @(negedge clock);
      end
   endtask

   // Bring the block to rest: no request pending, every result back, pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (exp_counts_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_LINE_MARKER:      cfg_m.line_marker  = val;
         CSR_LINE_MARKER_LEN:  cfg_m.line_len     = val[LEN_WIDTH-1:0];
         CSR_OPEN_MARKER:      cfg_m.open_marker  = val;
         CSR_OPEN_MARKER_LEN:  cfg_m.open_len     = val[LEN_WIDTH-1:0];
         CSR_CLOSE_MARKER:     cfg_m.close_marker = val;
         CSR_CLOSE_MARKER_LEN: cfg_m.close_len    = val[LEN_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Load all six registers; lengths carry junk above bit 3, which must be dropped
   task automatic load_markers(input logic [63:0] lm, input logic [LEN_WIDTH-1:0] ll,
                               input logic [63:0] om, input logic [LEN_WIDTH-1:0] ol,
                               input logic [63:0] cm, input logic [LEN_WIDTH-1:0] cl);
      logic [63:0] junk;
      junk = {$urandom, $urandom} & ~64'hF;
      write_reg(CSR_LINE_MARKER, lm);
      write_reg(CSR_LINE_MARKER_LEN, junk | 64'(ll));
      write_reg(CSR_OPEN_MARKER, om);
      write_reg(CSR_OPEN_MARKER_LEN, junk | 64'(ol));
      write_reg(CSR_CLOSE_MARKER, cm);
      write_reg(CSR_CLOSE_MARKER_LEN, junk | 64'(cl));
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, {$urandom, $urandom});
      @(negedge clock);
      csr_valid <= 1'b0;
      setups++;
   endtask

   function automatic logic [7:0] mark_byte();
      int idx;
      idx = $urandom_range(0, 7);
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom);
      return MARK_SET[8*idx +: 8];
   endfunction

   // Pick a marker setup. The first few rounds hit the extremes: every length above
   // the window, everything disabled, all-ones markers, an empty end marker, zero bytes.
   task automatic pick_markers(input int round);
      logic [63:0]          mk [3];
      logic [LEN_WIDTH-1:0] ln [3];
      int j, k;
      for (j = 0; j < 3; j++) begin
         for (k = 0; k < 8; k++)
            mk[j][8*k +: 8] = mark_byte();
         ln[j] = ($urandom_range(0, 5) == 0) ? LEN_WIDTH'($urandom_range(9, 15)) :
                                                LEN_WIDTH'($urandom_range(0, 8));
      end
      case (round)
         0: for (j = 0; j < 3; j++) ln[j] = 4'd15;
         1: for (j = 0; j < 3; j++) begin
               mk[j] = '0;
               ln[j] = 4'd0;
            end
         2: for (j = 0; j < 3; j++) begin
               mk[j] = '1;
               ln[j] = 4'd8;
            end
         3: begin
               ln[1] = LEN_WIDTH'($urandom_range(1, 3));
               ln[2] = 4'd0;
            end
         4: for (j = 0; j < 3; j++) begin
               mk[j] = '0;
               ln[j] = LEN_WIDTH'($urandom_range(1, 8));
            end
         default: if (ln[1] == 0) ln[1] = LEN_WIDTH'($urandom_range(1, 4));  // keep blocks mostly live
      endcase
      load_markers(mk[0], ln[0], mk[1], ln[1], mk[2], ln[2]);
   endtask

   // Marker prefix, sometimes cut short so the line ends before the marker does
   function automatic void push_marker(input logic [63:0] m, input logic [LEN_WIDTH-1:0] len);
      int cut, k;
      cut = int'(win_len(len));
      if ($urandom_range(0, 3) == 0)
         cut = $urandom_range(0, cut);
      for (k = 0; k < cut; k++)
         file_bytes.push_back(m[8*k +: 8]);
   endfunction

   // Line content: mostly marker bytes so partial and late matches happen
   function automatic logic [7:0] body_byte();
      int r, k;
      r = $urandom_range(0, 19);
      k = $urandom_range(0, 7);
      if (r < 4)
         return cfg_m.line_marker[8*k +: 8];
      if (r < 8)
         return cfg_m.open_marker[8*k +: 8];
      if (r < 12)
         return cfg_m.close_marker[8*k +: 8];
      if (r < 16)
         return 8'h61 + 8'($urandom_range(0, 25));
      if (r < 18)
         return SP_BYTE;
      if (r == 18)
         return NL_BYTE;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] space_byte();
      case ($urandom_range(0, 4))
         0: return SP_BYTE;
         1: return HT_BYTE;
         2: return CR_BYTE;
         3: return VT_BYTE;
         default: return FF_BYTE;
      endcase
   endfunction

   // Build one file of well-formed lines with random content, then send it. The end
   // either rides on the last byte or comes as a bare end transaction.
   task automatic send_file();
      int lines, li, n;
      bit open_tail, end_on_byte;
      logic [7:0] b;
      lines       = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      open_tail   = ($urandom_range(0, 3) == 0);
      end_on_byte = ($urandom_range(0, 1) == 1);
      file_bytes.delete();
      for (li = 0; li < lines; li++) begin
         n = $urandom_range(0, 3);
         repeat (n) file_bytes.push_back(space_byte());
         case ($urandom_range(0, 6))
            0, 1: push_marker(cfg_m.line_marker, cfg_m.line_len);
            2, 3: push_marker(cfg_m.open_marker, cfg_m.open_len);
            4:    push_marker(cfg_m.close_marker, cfg_m.close_len);
            5: begin
                  push_marker(cfg_m.open_marker, cfg_m.open_len);
                  push_marker(cfg_m.close_marker, cfg_m.close_len);
               end
            default: ;
         endcase
         n = $urandom_range(0, 6);
         repeat (n) file_bytes.push_back(body_byte());
         if (!(open_tail && li == lines - 1))
            file_bytes.push_back(NL_BYTE);
      end
      if (file_bytes.size() == 0)
         end_on_byte = 1'b0;
      while (file_bytes.size() > 0) begin
         b = file_bytes.pop_front();
         if ($urandom_range(0, 24) == 0)
            send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);   // empty step
         send_item(b, 1'b1, end_on_byte && file_bytes.size() == 0, 1'b0, '0);
      end
      if (!end_on_byte)
         send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
   endtask

   function automatic void add_row(input logic [7:0] b, input logic pres, input logic fin,
                                   input logic retune, input logic typed, input counts_t want);
      dir_rows.push_back({b, pres, fin, retune, typed, want});
   endfunction

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int round;
      dir_row_t row;

      wipe_counts();

      // Registers at reset: no markers. Empty file, a lone high byte, one blank line.
      add_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, {32'd0, 32'd0, 32'd0, 33'sd0});
      add_row(8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, {32'd1, 32'd0, 32'd0, 33'sd1});
      add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h5A, 1'b0, 1'b1, 1'b0, 1'b1, {32'd1, 32'd0, 32'd1, -33'sd0});
      // C-style markers from here on
      add_row(SP_BYTE, 1'b1, 1'b0, 1'b1, 1'b0, '0);   // indented line comment
      add_row(HT_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h2F,   1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h2F,   1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h2F,   1'b1, 1'b0, 1'b0, 1'b0, '0);   // line ends inside the marker
      add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h2F,   1'b1, 1'b0, 1'b0, 1'b0, '0);   // block opens
      add_row(8'h2A,   1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(CR_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);   // whitespace line inside the block
      add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h2A,   1'b1, 1'b0, 1'b0, 1'b0, '0);   // block closes; the line counts as a comment
      add_row(8'h2F,   1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hC3,   1'b0, 1'b0, 1'b0, 1'b0, '0);   // empty step
      add_row(VT_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);   // blank line of VT and FF
      add_row(FF_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);
      add_row(SP_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, '0);   // unterminated whitespace line
      add_row(SP_BYTE, 1'b1, 1'b1, 1'b0, 1'b0, '0);

      // Synchronous reset
      repeat (12)
         @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.retune) begin
            settle();
            load_markers(64'h2F2F, 4'd2, 64'h2A2F, 4'd2, 64'h2F2A, 4'd2);
         end
         send_item(row.text, row.present, row.fin, row.typed, row.want);
      end

      // Random part: each round loads a marker setup at rest, then sends a few files
      round = 0;
      while (items_sent < ITEM_GOAL) begin
         settle();
         if (items_sent >= CALM_AFTER)
            quiet_tail = 1'b1;
         pick_markers(round);
         repeat ($urandom_range(2, 5))
            send_file();
         round++;
      end
      settle();

      $display("Sent %0d transactions (%0d bytes) under %0d marker setups;",
               items_sent, bytes_sent, setups);
      $display("checked %0d file results, %0d mismatches.", files_seen, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/scl_pkg.sv
rtl/scl_front.sv
rtl/scl_fifo.sv
rtl/scl_back.sv
rtl/source_line_classifier_top.sv
tb/tb.sv
